### src/mbfr_pkg.sv
// ----------------------------------------------------------------------------
// mbfr_pkg: shared types and constants of the MSB-first bit-field reader
// Command and status codes, field widths and byte masks.
// ----------------------------------------------------------------------------
`default_nettype none

package mbfr_pkg;

	localparam int CMD_W    = 2;
	localparam int BYTE_W   = 8;
	localparam int WIDTH_W  = 7;
	localparam int VALUE_W  = 64;
	localparam int STATUS_W = 2;
	localparam int LEVEL_W  = 8;

	// longest field one read returns
	localparam logic [WIDTH_W-1:0] MAX_FIELD = 7'd64;

	localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hff;

	localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ALIGN = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

endpackage

`default_nettype wire

### src/mbfr_if.sv
// ----------------------------------------------------------------------------
// mbfr_item_if / mbfr_result_if: valid/ready channels of the bit-field reader
// A beat moves when valid and ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbfr_item_if import mbfr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [BYTE_W-1:0]  byte_in;
	logic [WIDTH_W-1:0] field_width;

	modport source (output valid, cmd, byte_in, field_width, input ready);
	modport sink   (input valid, cmd, byte_in, field_width, output ready);
endinterface

interface mbfr_result_if import mbfr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [VALUE_W-1:0]  field_value;
	logic [STATUS_W-1:0] status;
	logic [LEVEL_W-1:0]  bits_buffered;

	modport source (output valid, field_value, status, bits_buffered, input ready);
	modport sink   (input valid, field_value, status, bits_buffered, output ready);
endinterface

`default_nettype wire

### src/msb_first_bit_field_reader.sv
// ----------------------------------------------------------------------------
// msb_first_bit_field_reader: MSB-first bit-field extractor for a byte stream
// Pushes bytes into a bit store and returns fields of 0 to 64 bits per beat.
// ----------------------------------------------------------------------------
// Channels: item (sink) carries cmd, byte_in and field_width; result (source)
// carries field_value, status and bits_buffered, one result beat per item.
// cmd push appends byte_in, read returns the next field_width bits with the
// first stream bit most significant, align skips to the next byte boundary.
// A read longer than the buffered bits returns underflow and consumes nothing;
// a push into a full store returns overflow and drops the byte.
// The result passes through the input register and then the result register;
// a receiver stall can hold an item in either. The reader takes one item per
// cycle while the receiver takes results; the update of the store shifts the
// whole store by up to 64 bits on a read, or shifts the byte and its mask by
// the fill level on a push.
// The unread bits sit left-aligned in a shift register of STORE_BYTES*8 bits.
// Reset clears the fill level and the bit offset; the store contents need no
// clearing, so items are accepted right after reset.
// When the receiver stalls the result register holds; the input register
// still takes one more item, then ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module msb_first_bit_field_reader import mbfr_pkg::*; #(
	parameter int STORE_BYTES = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	mbfr_item_if.sink     item,
	mbfr_result_if.source result
);

	localparam int STORE_BITS = STORE_BYTES * 8;
	localparam int FILL_W     = $clog2(STORE_BITS + 1);

	// input stage
	logic               valid_s1;
	logic [CMD_W-1:0]   cmd_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic [WIDTH_W-1:0] width_s1;

	// result stage
	logic                valid_s2;
	logic [VALUE_W-1:0]  value_s2;
	logic [STATUS_W-1:0] status_s2;
	logic [LEVEL_W-1:0]  level_s2;

	// bit store state: next unread bit at the MSB
	logic [STORE_BITS-1:0] store_q;
	logic [FILL_W-1:0]     fill_q;
	logic [2:0]            off_q;

	logic                  advance;
	logic                  load_s1;
	logic [STORE_BITS-1:0] store_n;
	logic [FILL_W-1:0]     fill_n;
	logic [2:0]            off_n;
	logic [VALUE_W-1:0]    value_n;
	logic [STATUS_W-1:0]   status_n;
	logic [WIDTH_W-1:0]    width_sat;
	logic [FILL_W:0]       used_bits;
	logic [3:0]            drop;
	logic [VALUE_W-1:0]    head;
	logic [FILL_W+LEVEL_W-1:0] level_ext;

	assign advance    = !valid_s2 || result.ready;
	assign load_s1    = !valid_s1 || advance;
	assign item.ready = load_s1;

	assign width_sat = (width_s1 > MAX_FIELD) ? MAX_FIELD : width_s1;
	assign used_bits = {1'b0, fill_q} + (FILL_W+1)'(off_q);
	assign drop      = 4'd8 - {1'b0, off_q};
	assign head      = store_q[STORE_BITS-1 -: VALUE_W];

	always_comb begin
		store_n  = store_q;
		fill_n   = fill_q;
		off_n    = off_q;
		value_n  = '0;
		status_n = ST_OK;
		case (cmd_s1)
			CMD_PUSH: begin
				if (used_bits >= (FILL_W+1)'(STORE_BITS)) begin
					status_n = ST_OVERFLOW;
				end else begin
					// write the byte just below the unread bits
					store_n = (store_q & ~({BYTE_ONES, (STORE_BITS-BYTE_W)'(0)} >> fill_q))
						| ({byte_s1, (STORE_BITS-BYTE_W)'(0)} >> fill_q);
					fill_n  = fill_q + FILL_W'(BYTE_W);
				end
			end
			CMD_READ: begin
				if (FILL_W'(width_sat) > fill_q) begin
					status_n = ST_UNDERFLOW;
				end else begin
					value_n = head >> (MAX_FIELD - width_sat);
					store_n = store_q << width_sat;
					fill_n  = fill_q - FILL_W'(width_sat);
					off_n   = off_q + width_sat[2:0];
				end
			end
			CMD_ALIGN: begin
				if (off_q != 3'd0) begin
					store_n = store_q << drop;
					fill_n  = fill_q - FILL_W'(drop);
					off_n   = 3'd0;
				end
			end
			default: begin
			end
		endcase
	end

	assign level_ext = {LEVEL_W'(0), fill_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			fill_q   <= '0;
			off_q    <= '0;
		end else begin
			if (load_s1) begin
				valid_s1 <= item.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					fill_q <= fill_n;
					off_q  <= off_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && item.valid) begin
			cmd_s1   <= item.cmd;
			byte_s1  <= item.byte_in;
			width_s1 <= item.field_width;
		end
		if (advance && valid_s1) begin
			store_q   <= store_n;
			value_s2  <= value_n;
			status_s2 <= status_n;
			level_s2  <= level_ext[LEVEL_W-1:0];
		end
	end

	assign result.valid         = valid_s2;
	assign result.field_value   = value_s2;
	assign result.status        = status_s2;
	assign result.bits_buffered = level_s2;

`ifndef SYNTH
	// fill never exceeds the store
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(STORE_BITS))
		else $error("fill level beyond store size");

	// unread bits always end on a byte boundary
	a_byte_end: assert property (@(posedge clk) disable iff (!arst_n)
		used_bits[2:0] == 3'd0)
		else $error("offset plus fill not byte aligned");

	// a failed item returns no field bits
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && status_s2 != ST_OK) |-> (value_s2 == '0))
		else $error("nonzero field on error status");

	// a stalled result leaves the store state alone
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !result.ready) |=> ($stable(fill_q) && $stable(off_q)))
		else $error("state moved while result stalled");
`endif

endmodule

`default_nettype wire

### dv/mbfr_field_checker.sv
// ----------------------------------------------------------------------------
// mbfr_field_checker: result predictor and scoreboard of the bit-field reader
// Watches the item and result channels, keeps its own copy of the byte ring,
// the bit pointer and the fill level, works out the result of every item beat
// and compares each result beat field by field with the oldest one pending.
// ----------------------------------------------------------------------------
module mbfr_field_checker import mbfr_pkg::*; #(
	parameter int STORE_BYTES = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mbfr_item_if      item,
	mbfr_result_if    result,
	output int        errors,
	output int        pending
);

	typedef struct packed {
		logic [VALUE_W-1:0]  value;
		logic [STATUS_W-1:0] status;
		logic [LEVEL_W-1:0]  level;
	} field_result_t;

	localparam int RING_BITS = STORE_BYTES * BYTE_W;

	logic [BYTE_W-1:0] byte_ring [STORE_BYTES];
	int                bit_ptr   = 0;
	int                bits_held = 0;
	int                fail_tally = 0;
	int                queued     = 0;
	field_result_t     expected_fields [$];
	field_result_t     want;

	assign errors  = fail_tally;
	assign pending = queued;

	function automatic field_result_t reader_response(input logic [CMD_W-1:0] cmd,
			input logic [BYTE_W-1:0] data, input logic [WIDTH_W-1:0] req_width);
		field_result_t r;
		int            held_bytes;
		int            span;
		int            skip;
		int            i;
		r = '0;
		case (cmd)
			CMD_PUSH: begin
				// bytes touched by unread bits, a partly read one included
				held_bytes = ((bit_ptr % BYTE_W) + bits_held) / BYTE_W;
				if (held_bytes >= STORE_BYTES) begin
					r.status = ST_OVERFLOW;
				end else begin
					byte_ring[((bit_ptr / BYTE_W) + held_bytes) % STORE_BYTES] = data;
					bits_held += BYTE_W;
				end
			end
			CMD_READ: begin
				span = (req_width > MAX_FIELD) ? int'(MAX_FIELD) : int'(req_width);
				if (span > bits_held) begin
					r.status = ST_UNDERFLOW;
				end else begin
					for (i = 0; i < span; i++) begin
						r.value = {r.value[VALUE_W-2:0],
							byte_ring[bit_ptr / BYTE_W][BYTE_W - 1 - (bit_ptr % BYTE_W)]};
						bit_ptr = (bit_ptr + 1) % RING_BITS;
						bits_held--;
					end
				end
			end
			CMD_ALIGN: begin
				if (bit_ptr % BYTE_W != 0) begin
					skip = BYTE_W - (bit_ptr % BYTE_W);
					bits_held -= skip;
					bit_ptr = (bit_ptr + skip) % RING_BITS;
				end
			end
			default: ;
		endcase
		r.level = LEVEL_W'(bits_held);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_ptr = 0;
			bits_held = 0;
			expected_fields.delete();
		end else begin
			// a result beat never belongs to an item taken at the same edge
			if (result.valid && result.ready) begin
				if (expected_fields.size() == 0) begin
					$error("result beat with no item pending");
					fail_tally++;
				end else begin
					want = expected_fields.pop_front();
					if (result.field_value !== want.value) begin
						$error("field_value: expected %h, got %h", want.value, result.field_value);
						fail_tally++;
					end
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						fail_tally++;
					end
					if (result.bits_buffered !== want.level) begin
						$error("bits_buffered: expected %0d, got %0d", want.level,
							result.bits_buffered);
						fail_tally++;
					end
				end
			end
			if (item.valid && item.ready)
				expected_fields.push_back(reader_response(item.cmd, item.byte_in, item.field_width));
		end
		queued <= expected_fields.size();
	end

endmodule

### dv/tb_msb_first_bit_field_reader.sv
// ----------------------------------------------------------------------------
// tb_msb_first_bit_field_reader: testbench of the MSB-first bit-field reader
// Drives a directed run over the field extremes, every command and the edge
// cases of the store, then random traffic of all four command codes in blocks biased
// toward filling or draining, under phases of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_msb_first_bit_field_reader;
	import mbfr_pkg::*;

	localparam int STORE_BYTES = 16;
	localparam int RANDOM_ITEMS = 425;
	localparam int BLOCK_ITEMS = 40;
	localparam int QUIET_LIMIT = 4000;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   gap_pct = 0;
	int   stall_pct = 0;
	int   push_pct = 50;
	int   quiet = 0;
	int   errors;
	int   pending;

	mbfr_item_if   item_ch ();
	mbfr_result_if result_ch ();

	msb_first_bit_field_reader #(.STORE_BYTES(STORE_BYTES)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	mbfr_field_checker #(.STORE_BYTES(STORE_BYTES)) checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk)
		result_ch.ready <= ($urandom_range(99) >= stall_pct);

	// end the run when no beat moves on either channel for too long
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("tb_msb_first_bit_field_reader failed");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] b,
			input logic [WIDTH_W-1:0] w);
		if ($urandom_range(99) < gap_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < gap_pct)
				@(posedge clk);
		end
		item_ch.valid       <= 1'b1;
		item_ch.cmd         <= c;
		item_ch.byte_in     <= b;
		item_ch.field_width <= w;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
	endtask

	// mostly short fields, some long ones, a few above the saturation point
	function automatic logic [WIDTH_W-1:0] pick_width();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 60)
			return WIDTH_W'($urandom_range(16));
		if (roll < 90)
			return WIDTH_W'($urandom_range(64, 17));
		return WIDTH_W'($urandom_range(127, 65));
	endfunction

	task automatic send_random_item();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < push_pct)
			send_item(CMD_PUSH, BYTE_W'($urandom), pick_width());
		else if (roll < push_pct + (100 - push_pct) * 8 / 10)
			send_item(CMD_READ, BYTE_W'($urandom), pick_width());
		else if (roll < 98)
			send_item(CMD_ALIGN, BYTE_W'($urandom), pick_width());
		else
			send_item(CMD_UNUSED, BYTE_W'($urandom), pick_width());
	endtask

	task automatic run_directed();
		logic [BYTE_W-1:0] edge_bytes [5];
		int                i;
		edge_bytes = '{BYTE_ONES, 8'h00, 8'h80, 8'hc0, 8'hfe};
		send_item(CMD_READ, 8'h00, 7'd0);
		send_item(CMD_ALIGN, 8'h00, 7'd0);
		send_item(CMD_UNUSED, BYTE_ONES, 7'd127);
		// fill the store to the brim, then one push too many
		for (i = 0; i < STORE_BYTES; i++)
			send_item(CMD_PUSH, (i < 5) ? edge_bytes[i] : BYTE_W'($urandom), 7'd0);
		send_item(CMD_PUSH, 8'h5a, 7'd0);
		send_item(CMD_READ, 8'h00, 7'd3);
		send_item(CMD_ALIGN, 8'h00, 7'd0);
		send_item(CMD_READ, 8'h00, 7'd127);
		send_item(CMD_READ, 8'h00, MAX_FIELD);
		send_item(CMD_READ, 8'h00, 7'd56);
	endtask

	task automatic run_phase(input int sender_gap, input int receiver_stall);
		int n;
		gap_pct = sender_gap;
		stall_pct = receiver_stall;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			// swing between filling and draining the store
			if (n % BLOCK_ITEMS == 0)
				push_pct = 25 * $urandom_range(3, 1);
			send_random_item();
		end
	endtask

	initial begin
		item_ch.valid = 1'b0;
		item_ch.cmd = CMD_PUSH;
		item_ch.byte_in = '0;
		item_ch.field_width = '0;
		result_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_phase(0, 0);
		run_phase(52, 0);
		run_phase(0, 52);
		run_phase(6, 6);
		item_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("tb_msb_first_bit_field_reader passed");
		else
			$display("tb_msb_first_bit_field_reader failed");
		$finish;
	end

endmodule

### filelist.f
src/mbfr_pkg.sv
src/mbfr_if.sv
src/msb_first_bit_field_reader.sv
dv/mbfr_field_checker.sv
dv/tb_msb_first_bit_field_reader.sv
